FILE: hdl/tfms_pkg.sv
// Package for the turbulent field mode sum block: sizes, mode word layout,
// pipeline sideband, controller states and fixed-point helpers.
// No dependencies.
`default_nettype none

package tfms_pkg;

    localparam int NUM_MODES = 64;
    localparam int MODE_W    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int NUM_TRIG  = 4;
    localparam int NUM_SLOTS = NUM_MODES + NUM_TRIG;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    // config register indexes
    localparam logic [1:0] CFG_STRENGTH = 2'd0;
    localparam logic [1:0] CFG_TILT     = 2'd1;
    localparam logic [1:0] CFG_AZIMUTH  = 2'd2;
    localparam logic [1:0] CFG_FLUCT    = 2'd3;

    // background trig slots
    localparam logic [1:0] TRIG_COS_TH = 2'd0;
    localparam logic [1:0] TRIG_SIN_TH = 2'd1;
    localparam logic [1:0] TRIG_COS_PH = 2'd2;
    localparam logic [1:0] TRIG_SIN_PH = 2'd3;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [22:0] DIV45_MUL    = 23'd5965233; // ceil(2^28 / 45)

    // Horner coefficients, Q30: c9, -c7, c5, -c3, c1
    localparam logic signed [31:0] SIN_C [0:4] = '{
        32'sd172272, -32'sd5026995, 32'sd85569305, -32'sd693598668, 32'sd1686629713
    };

    typedef struct packed {
        logic        [15:0] phase;
        logic signed [17:0] pol_z;
        logic signed [17:0] pol_y;
        logic signed [17:0] pol_x;
        logic signed [24:0] wave_z;
        logic signed [24:0] wave_y;
        logic signed [24:0] wave_x;
    } t_mode;

    typedef struct packed {
        logic               trig;
        logic        [1:0]  tidx;
        logic signed [17:0] pol_x;
        logic signed [17:0] pol_y;
        logic signed [17:0] pol_z;
    } t_side;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_DRAIN, ST_BG1, ST_BG2, ST_FLUSH, ST_DONE
    } t_state;

    // shift right by 30, rounding half away from zero
    function automatic logic signed [63:0] rshr30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r = (mag + 64'h0000_0000_2000_0000) >> 30;
        rshr30 = v[63] ? -$signed(r) : $signed(r);
    endfunction

    // degrees Q8 to turns Q16: ((d*32+22)/45) mod 2^16
    function automatic logic [15:0] deg_to_turn(input logic [16:0] d);
        logic [21:0] x;
        logic [44:0] m;
        x = {d, 5'b0} + 22'd22;
        m = x * DIV45_MUL;
        deg_to_turn = m[43:28];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/turbulent_field_mode_sum.sv
// Turbulent field mode sum: background field plus a frozen Fourier mode sum.
// Uses tfms_pkg, tfms_ram (mode table) and tfms_cos (cosine pipeline).
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser command, tdata mode / position
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata field x, y, z
//  cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_data
//
// A load transaction writes its mode entry straight into the table. An evaluate transaction
// holds the input off until its result is loaded into the output register: four trig
// slots and one mode per cycle are issued from the table into the cosine pipeline, then
// the pipeline drains and the background terms are added. Reset is synchronous; mode
// entries read as zero until loaded. The result waits in an output register; a new
// transaction is taken while it waits, a finished evaluation holds until that register frees.
`default_nettype none

module turbulent_field_mode_sum (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode_index, wave_x, wave_y, wave_z, pol_x, pol_y, pol_z, mode_phase,
    // pos_x, pos_y, pos_z, one pad bit
    input  wire logic [247:0] s_axis_tdata,
    // command
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // field_x, field_y, field_z
    output logic [95:0]       m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [17:0]  i_cfg_data
);

    localparam int MW = tfms_pkg::MODE_W;
    localparam int SW = tfms_pkg::SLOT_W;

    tfms_pkg::t_state r_state, n_state;

    logic [17:0] r_strength;
    logic [15:0] r_tilt;
    logic [16:0] r_azimuth;
    logic [17:0] r_fluct;
    logic [15:0] r_th, r_ph;
    logic [20:0] r_a;

    logic [tfms_pkg::NUM_MODES-1:0] r_mvalid;
    logic [SW-1:0]        r_cnt;
    logic signed [31:0]   r_pos_x, r_pos_y, r_pos_z;

    logic                 w_accept, w_load, w_eval;
    logic                 w_issue, w_bg1, w_bg2, w_out_load;
    logic [SW-1:0]        w_slot_m;
    logic [MW-1:0]        w_raddr;
    tfms_pkg::t_mode      w_ram_q, w_md;

    // stage B
    logic                 r_b_vld, r_b_trig, r_b_ok;
    logic [1:0]           r_b_tidx;
    logic [15:0]          r_b_tph;
    logic signed [56:0]   w_px, w_py, w_pz;
    // stage C
    logic                 r_c_vld;
    logic [31:0]          r_c_px, r_c_py, r_c_pz;
    logic [15:0]          r_c_phase, r_c_tph;
    tfms_pkg::t_side      r_c_side;
    logic [31:0]          w_t;
    // cosine input
    logic                 r_k_vld;
    logic [15:0]          r_k_phase;
    tfms_pkg::t_side      r_k_side;
    logic                 cos_vld, cos_busy;
    logic signed [17:0]   cos_val;
    tfms_pkg::t_side      cos_side;
    logic signed [17:0]   r_trig [tfms_pkg::NUM_TRIG];
    // multiply stages
    logic                 w_m_vld;
    logic [20:0]          w_m_a;
    logic signed [17:0]   w_m_cos, w_m_px, w_m_py, w_m_pz;
    logic signed [39:0]   w_c;
    logic                 r_m_vld;
    logic signed [39:0]   r_m_c;
    logic signed [17:0]   r_m_px, r_m_py, r_m_pz;
    logic                 r_t_vld;
    logic signed [57:0]   r_t_x, r_t_y, r_t_z;
    logic signed [63:0]   r_acc_x, r_acc_y, r_acc_z;

    logic                 r_out_vld;
    logic [95:0]          r_out;

    function automatic logic [31:0] sat_q48(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [32:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r = 33'((mag + 64'h0000_0000_8000_0000) >> 32);
        if (!v[63]) begin
            sat_q48 = (r > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end else begin
            sat_q48 = (r > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-r[31:0]);
        end
    endfunction

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_eval   = w_accept && s_axis_tuser;
    assign w_load   = w_accept && !s_axis_tuser
                      && (9'(s_axis_tdata[5:0]) < 9'(tfms_pkg::NUM_MODES));

    // configuration and derived constants
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= 18'd65536;
            r_tilt     <= '0;
            r_azimuth  <= '0;
            r_fluct    <= 18'd19661;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tfms_pkg::CFG_STRENGTH: r_strength <= i_cfg_data;
                tfms_pkg::CFG_TILT:     r_tilt     <= i_cfg_data[15:0];
                tfms_pkg::CFG_AZIMUTH:  r_azimuth  <= i_cfg_data[16:0];
                tfms_pkg::CFG_FLUCT:    r_fluct    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_th <= tfms_pkg::deg_to_turn({1'b0, r_tilt});
        r_ph <= tfms_pkg::deg_to_turn(r_azimuth);
        r_a  <= 21'(((37'(r_fluct) * 37'(r_strength)) + 37'd32768) >> 16);
    end

    // mode table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= '0;
        end else if (w_load) begin
            r_mvalid[s_axis_tdata[MW-1:0]] <= 1'b1;
        end
    end

    assign w_slot_m = r_cnt - SW'(tfms_pkg::NUM_TRIG);
    assign w_raddr  = w_slot_m[MW-1:0];

    tfms_ram #(
        .WIDTH($bits(tfms_pkg::t_mode)),
        .DEPTH(tfms_pkg::NUM_MODES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_load),
        .i_waddr(s_axis_tdata[MW-1:0]),
        .i_wdata(s_axis_tdata[150:6]),
        .i_raddr(w_raddr),
        .o_rdata(w_ram_q)
    );

    // controller
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tfms_pkg::ST_IDLE:  if (w_eval) n_state = tfms_pkg::ST_ISSUE;
            tfms_pkg::ST_ISSUE: if (r_cnt == SW'(tfms_pkg::NUM_SLOTS - 1)) begin
                n_state = tfms_pkg::ST_DRAIN;
            end
            tfms_pkg::ST_DRAIN: if (!r_b_vld && !r_c_vld && !r_k_vld && !cos_busy
                                    && !r_m_vld && !r_t_vld) begin
                n_state = tfms_pkg::ST_BG1;
            end
            tfms_pkg::ST_BG1:   n_state = tfms_pkg::ST_BG2;
            tfms_pkg::ST_BG2:   n_state = tfms_pkg::ST_FLUSH;
            tfms_pkg::ST_FLUSH: if (!r_m_vld && !r_t_vld) n_state = tfms_pkg::ST_DONE;
            tfms_pkg::ST_DONE:  if (!r_out_vld || m_axis_tready) n_state = tfms_pkg::ST_IDLE;
            default:            n_state = tfms_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == tfms_pkg::ST_IDLE);
        w_issue       = (r_state == tfms_pkg::ST_ISSUE);
        w_bg1         = (r_state == tfms_pkg::ST_BG1);
        w_bg2         = (r_state == tfms_pkg::ST_BG2);
        w_out_load    = (r_state == tfms_pkg::ST_DONE) && (!r_out_vld || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfms_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_cnt   <= '0;
            r_pos_x <= s_axis_tdata[182:151];
            r_pos_y <= s_axis_tdata[214:183];
            r_pos_z <= s_axis_tdata[246:215];
        end else if (w_issue) begin
            r_cnt <= r_cnt + SW'(1);
        end
    end

    // stage B: table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_trig <= (r_cnt < SW'(tfms_pkg::NUM_TRIG));
        r_b_tidx <= r_cnt[1:0];
        r_b_ok   <= r_mvalid[w_raddr];
        unique case (r_cnt[1:0])
            tfms_pkg::TRIG_COS_TH: r_b_tph <= r_th;
            tfms_pkg::TRIG_SIN_TH: r_b_tph <= r_th - tfms_pkg::QUARTER_TURN;
            tfms_pkg::TRIG_COS_PH: r_b_tph <= r_ph;
            tfms_pkg::TRIG_SIN_PH: r_b_tph <= r_ph - tfms_pkg::QUARTER_TURN;
        endcase
    end

    always_comb begin
        w_md = r_b_ok ? w_ram_q : '0;
        w_px = w_md.wave_x * r_pos_x;
        w_py = w_md.wave_y * r_pos_y;
        w_pz = w_md.wave_z * r_pos_z;
    end

    // stage C: k.x products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_px         <= w_px[31:0];
        r_c_py         <= w_py[31:0];
        r_c_pz         <= w_pz[31:0];
        r_c_phase      <= w_md.phase;
        r_c_tph        <= r_b_tph;
        r_c_side.trig  <= r_b_trig;
        r_c_side.tidx  <= r_b_tidx;
        r_c_side.pol_x <= w_md.pol_x;
        r_c_side.pol_y <= w_md.pol_y;
        r_c_side.pol_z <= w_md.pol_z;
    end

    assign w_t = r_c_px + r_c_py + r_c_pz + {r_c_phase, 16'b0} + 32'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else begin
            r_k_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_phase <= r_c_side.trig ? r_c_tph : w_t[31:16];
        r_k_side  <= r_c_side;
    end

    tfms_cos u_cos (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_k_vld),
        .i_phase(r_k_phase),
        .i_side (r_k_side),
        .o_vld  (cos_vld),
        .o_cos  (cos_val),
        .o_side (cos_side),
        .o_busy (cos_busy)
    );

    always_ff @(posedge i_clk) begin
        if (cos_vld && cos_side.trig) begin
            r_trig[cos_side.tidx] <= cos_val;
        end
    end

    // scale and polarization multiplies
    always_comb begin
        w_m_vld = 1'b0;
        w_m_a   = r_a;
        w_m_cos = cos_val;
        w_m_px  = cos_side.pol_x;
        w_m_py  = cos_side.pol_y;
        w_m_pz  = cos_side.pol_z;
        priority if (cos_vld && !cos_side.trig) begin
            w_m_vld = 1'b1;
        end else if (w_bg1) begin
            w_m_vld = 1'b1;
            w_m_a   = 21'(r_strength);
            w_m_cos = r_trig[tfms_pkg::TRIG_SIN_TH];
            w_m_px  = r_trig[tfms_pkg::TRIG_COS_PH];
            w_m_py  = r_trig[tfms_pkg::TRIG_SIN_PH];
            w_m_pz  = '0;
        end else if (w_bg2) begin
            w_m_vld = 1'b1;
            w_m_a   = 21'(r_strength);
            w_m_cos = r_trig[tfms_pkg::TRIG_COS_TH];
            w_m_px  = '0;
            w_m_py  = '0;
            w_m_pz  = 18'sd65536;
        end else begin
            w_m_vld = 1'b0;
        end
        w_c = $signed({1'b0, w_m_a}) * w_m_cos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_t_vld <= 1'b0;
        end else begin
            r_m_vld <= w_m_vld;
            r_t_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_c  <= w_c;
        r_m_px <= w_m_px;
        r_m_py <= w_m_py;
        r_m_pz <= w_m_pz;
        r_t_x  <= r_m_c * r_m_px;
        r_t_y  <= r_m_c * r_m_py;
        r_t_z  <= r_m_c * r_m_pz;
    end

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (r_t_vld) begin
            r_acc_x <= r_acc_x + 64'(r_t_x);
            r_acc_y <= r_acc_y + 64'(r_t_y);
            r_acc_z <= r_acc_z + 64'(r_t_z);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= {sat_q48(r_acc_z), sat_q48(r_acc_y), sat_q48(r_acc_x)};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_state == tfms_pkg::ST_IDLE)
        else $error("mode write during evaluation");
    a_bg_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bg1 |-> (!r_m_vld && !cos_busy && !r_k_vld))
        else $error("background injected into busy pipeline");
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == tfms_pkg::ST_DONE)
        else $error("result without evaluation");
    a_issue_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && r_cnt == SW'(tfms_pkg::NUM_SLOTS - 1)) |=> r_state == tfms_pkg::ST_DRAIN)
        else $error("issue count overrun");
`endif

endmodule

`default_nettype wire

FILE: hdl/tfms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module tfms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/tfms_cos.sv
// Pipelined cosine of a 16 bit phase in turns, Q16 result, six stages.
// Degree 9 odd polynomial by Horner, one multiply per stage. Uses tfms_pkg.
`default_nettype none

module tfms_cos (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_vld,
    input  wire logic [15:0]           i_phase,
    input  wire tfms_pkg::t_side       i_side,
    output logic                       o_vld,
    output logic signed [17:0]         o_cos,
    output tfms_pkg::t_side            o_side,
    output logic                       o_busy
);

    localparam int NST = 6;

    logic                  r_vld  [NST];
    tfms_pkg::t_side       r_side [NST];
    logic                  r_neg  [NST-1];
    logic [16:0]           r_u    [NST-1];
    logic [30:0]           r_u2   [NST-1];
    logic signed [31:0]    r_p    [1:NST-2];
    logic signed [17:0]    r_cos;

    logic [14:0]           w_v;
    logic [29:0]           w_vsq;
    logic signed [63:0]    w_fin;
    logic signed [63:0]    w_s;
    logic signed [17:0]    w_mag;

    function automatic logic [14:0] QUARTER_SUB(input logic [13:0] r);
        QUARTER_SUB = 15'(tfms_pkg::QUARTER_TURN) - {1'b0, r};
    endfunction

    always_comb begin
        w_v   = i_phase[14] ? {1'b0, i_phase[13:0]} : 15'(QUARTER_SUB(i_phase[13:0]));
        w_vsq = w_v * w_v;
        w_fin = r_p[NST-2] * $signed({15'b0, r_u[NST-2]});
        w_s   = tfms_pkg::rshr30(w_fin);
        if (w_s < 0) begin
            w_mag = '0;
        end else if (w_s > 64'sd65536) begin
            w_mag = 18'sd65536;
        end else begin
            w_mag = w_s[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < NST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_neg[0]  <= i_phase[15] ^ i_phase[14];
        r_u[0]    <= {w_v, 2'b00};
        r_u2[0]   <= {1'b0, w_vsq} << 2 | 31'd0;
        for (int i = 1; i < NST; i++) begin
            r_side[i] <= r_side[i-1];
        end
        for (int i = 1; i < NST-1; i++) begin
            r_neg[i] <= r_neg[i-1];
            r_u[i]   <= r_u[i-1];
            r_u2[i]  <= r_u2[i-1];
        end
        for (int k = 1; k <= NST-2; k++) begin
            r_p[k] <= tfms_pkg::SIN_C[k] + 32'(tfms_pkg::rshr30(
                ((k == 1) ? 64'(tfms_pkg::SIN_C[0]) : 64'(r_p[k == 1 ? 1 : k-1]))
                * $signed({33'b0, r_u2[k-1]})));
        end
        r_cos <= r_neg[NST-2] ? -w_mag : w_mag;
    end

    assign o_vld  = r_vld[NST-1];
    assign o_cos  = r_cos;
    assign o_side = r_side[NST-1];

    always_comb begin
        o_busy = 1'b0;
        for (int i = 0; i < NST; i++) begin
            o_busy = o_busy | r_vld[i];
        end
    end

`ifndef SYNTHESIS
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_cos <= 18'sd65536 && o_cos >= -18'sd65536))
        else $error("cosine out of range");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> o_busy)
        else $error("output valid without busy");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |=> ##5 o_vld)
        else $error("cosine latency broken");
`endif

endmodule

`default_nettype wire
